// ----- src/pomse_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pomse_pkg
// Shared types, constants and codes of the polynomial ODE residual block.
// ----------------------------------------------------------------------------
package pomse_pkg;

  localparam int unsigned CountW    = 17;
  localparam logic [CountW-1:0] COUNT_CAP = 17'd65536;
  localparam int unsigned DivSteps  = 64;
  localparam logic [62:0] SQ_SAT    = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [51:0] ROOT_MAX  = 52'd3037000499;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_SHORT     = 2'd1;
  localparam logic [1:0] STATUS_ZERO_STEP = 2'd2;
  localparam logic [1:0] STATUS_RSVD      = 2'd3;

  typedef struct packed {
    logic signed [31:0] sample_time;
    logic signed [31:0] position;
    logic signed [31:0] force_req;
    logic               last_sample;
  } in_word_t;

  typedef struct packed {
    logic [62:0] mean_sq_error;
    logic [1:0]  status;
  } out_word_t;

  typedef struct packed {
    logic [1:0]         degree;
    logic signed [31:0] pos_coef0;
    logic signed [31:0] pos_coef1;
    logic signed [31:0] pos_coef2;
    logic signed [31:0] vel_coef0;
    logic signed [31:0] vel_coef1;
    logic signed [31:0] vel_coef2;
    logic signed [31:0] force_gain;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_DEGREE     = 3'd0,
    REG_POS_COEF0  = 3'd1,
    REG_POS_COEF1  = 3'd2,
    REG_POS_COEF2  = 3'd3,
    REG_VEL_COEF0  = 3'd4,
    REG_VEL_COEF1  = 3'd5,
    REG_VEL_COEF2  = 3'd6,
    REG_FORCE_GAIN = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    DV_DNEW,
    DV_D2A,
    DV_DK,
    DV_D2B,
    DV_D2C,
    DV_MEAN
  } div_sel_e;

  typedef enum logic [3:0] {
    ST_POS_LIN,
    ST_POS_SQ,
    ST_POS_QUAD,
    ST_VEL_LIN,
    ST_VEL_SQ,
    ST_VEL_QUAD,
    ST_FORCE,
    ST_RESID,
    ST_SQUARE
  } acc_step_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DNEW,
    S_D2A,
    S_ACCA,
    S_SHIFT,
    S_DK,
    S_D2B,
    S_ACCB,
    S_D2C,
    S_ACCC,
    S_MEAN,
    S_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic      load;
    logic      div_go;
    div_sel_e  div_sel;
    logic      acc_mul;
    logic      acc_post;
    acc_step_e acc_step;
    logic      acc_end;
    logic      shift;
    logic      emit;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic last;
    logic div_busy;
    logic out_busy;
  } dp_stat_t;

endpackage

// ----- src/pomse_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pomse_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module pomse_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output pomse_pkg::cfg_t     cfg_o
);

  pomse_pkg::cfg_t     cfg_q;
  pomse_pkg::reg_idx_e idx;
  logic                wr_en;

  assign idx    = pomse_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= {2'd1, 224'd0};
    end else if (wr_en) begin
      unique case (idx)
        pomse_pkg::REG_DEGREE:     cfg_q.degree     <= pwdata[1:0];
        pomse_pkg::REG_POS_COEF0:  cfg_q.pos_coef0  <= pwdata;
        pomse_pkg::REG_POS_COEF1:  cfg_q.pos_coef1  <= pwdata;
        pomse_pkg::REG_POS_COEF2:  cfg_q.pos_coef2  <= pwdata;
        pomse_pkg::REG_VEL_COEF0:  cfg_q.vel_coef0  <= pwdata;
        pomse_pkg::REG_VEL_COEF1:  cfg_q.vel_coef1  <= pwdata;
        pomse_pkg::REG_VEL_COEF2:  cfg_q.vel_coef2  <= pwdata;
        pomse_pkg::REG_FORCE_GAIN: cfg_q.force_gain <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      pomse_pkg::REG_DEGREE:     prdata = {30'd0, cfg_q.degree};
      pomse_pkg::REG_POS_COEF0:  prdata = cfg_q.pos_coef0;
      pomse_pkg::REG_POS_COEF1:  prdata = cfg_q.pos_coef1;
      pomse_pkg::REG_POS_COEF2:  prdata = cfg_q.pos_coef2;
      pomse_pkg::REG_VEL_COEF0:  prdata = cfg_q.vel_coef0;
      pomse_pkg::REG_VEL_COEF1:  prdata = cfg_q.vel_coef1;
      pomse_pkg::REG_VEL_COEF2:  prdata = cfg_q.vel_coef2;
      pomse_pkg::REG_FORCE_GAIN: prdata = cfg_q.force_gain;
    endcase
  end

endmodule

// ----- src/pomse_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pomse_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pomse_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [32:0] den_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [63:0] quo_o
);

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [63:0] quo_q;
  logic [32:0] rem_q, den_q;
  logic [33:0] trial;
  logic        ge;

  assign trial  = {rem_q, quo_q[63]};
  assign ge     = trial >= {1'b0, den_q};
  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(pomse_pkg::DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[62:0], ge};
      rem_q <= ge ? 33'(trial - {1'b0, den_q}) : trial[32:0];
    end
  end

endmodule

// ----- src/pomse_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pomse_ctrl
// Sequencer that steps the datapath through each sample word.
// ----------------------------------------------------------------------------
module pomse_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pomse_pkg::dp_stat_t stat_i,
  output pomse_pkg::dp_cmd_t  cmd_o
);

  pomse_pkg::ctrl_state_e state_q, state_d;
  pomse_pkg::acc_step_e   step_q, step_d;
  logic                   issued_q, issued_d;
  logic                   div_state, acc_state;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pomse_pkg::S_IDLE;
      step_q   <= pomse_pkg::ST_POS_LIN;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      issued_q <= issued_d;
    end
  end

  always_comb begin
    div_state = (state_q == pomse_pkg::S_DNEW) || (state_q == pomse_pkg::S_D2A) ||
                (state_q == pomse_pkg::S_DK) || (state_q == pomse_pkg::S_D2B) ||
                (state_q == pomse_pkg::S_D2C) || (state_q == pomse_pkg::S_MEAN);
    acc_state = (state_q == pomse_pkg::S_ACCA) || (state_q == pomse_pkg::S_ACCB) ||
                (state_q == pomse_pkg::S_ACCC);
  end

  // Next state.
  always_comb begin
    logic adv;
    adv      = 1'b0;
    state_d  = state_q;
    step_d   = step_q;
    issued_d = issued_q;
    if (div_state) begin
      if (!issued_q) begin
        issued_d = 1'b1;
      end else if (!stat_i.div_busy) begin
        issued_d = 1'b0;
        adv      = 1'b1;
      end
    end else if (acc_state) begin
      issued_d = !issued_q;
      if (issued_q) begin
        if (step_q == pomse_pkg::ST_SQUARE) begin
          step_d = pomse_pkg::ST_POS_LIN;
          adv    = 1'b1;
        end else begin
          step_d = pomse_pkg::acc_step_e'(step_q + 4'd1);
        end
      end
    end
    unique case (state_q)
      pomse_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = stat_i.cnt_zero ? pomse_pkg::S_SHIFT : pomse_pkg::S_DNEW;
        end
      end
      pomse_pkg::S_DNEW: begin
        if (adv) begin
          state_d = stat_i.cnt_one ? pomse_pkg::S_SHIFT : pomse_pkg::S_D2A;
        end
      end
      pomse_pkg::S_D2A:  if (adv) state_d = pomse_pkg::S_ACCA;
      pomse_pkg::S_ACCA: if (adv) state_d = pomse_pkg::S_SHIFT;
      pomse_pkg::S_SHIFT: begin
        if (!stat_i.last) begin
          state_d = pomse_pkg::S_IDLE;
        end else begin
          state_d = stat_i.cnt_zero ? pomse_pkg::S_EMIT : pomse_pkg::S_DK;
        end
      end
      pomse_pkg::S_DK:   if (adv) state_d = pomse_pkg::S_D2B;
      pomse_pkg::S_D2B:  if (adv) state_d = pomse_pkg::S_ACCB;
      pomse_pkg::S_ACCB: if (adv) state_d = pomse_pkg::S_D2C;
      pomse_pkg::S_D2C:  if (adv) state_d = pomse_pkg::S_ACCC;
      pomse_pkg::S_ACCC: if (adv) state_d = pomse_pkg::S_MEAN;
      pomse_pkg::S_MEAN: if (adv) state_d = pomse_pkg::S_EMIT;
      pomse_pkg::S_EMIT: if (!stat_i.out_busy) state_d = pomse_pkg::S_IDLE;
      default:           state_d = pomse_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o          = '0;
    cmd_o.div_sel  = pomse_pkg::DV_DNEW;
    cmd_o.acc_step = step_q;
    in_ready_o     = (state_q == pomse_pkg::S_IDLE);
    cmd_o.load     = in_ready_o && in_valid_i;
    cmd_o.div_go   = div_state && !issued_q;
    cmd_o.acc_mul  = acc_state && !issued_q;
    cmd_o.acc_post = acc_state && issued_q;
    cmd_o.acc_end  = (state_q == pomse_pkg::S_ACCC);
    cmd_o.shift    = (state_q == pomse_pkg::S_SHIFT);
    cmd_o.emit     = (state_q == pomse_pkg::S_EMIT) && !stat_i.out_busy;
    unique case (state_q)
      pomse_pkg::S_D2A:  cmd_o.div_sel = pomse_pkg::DV_D2A;
      pomse_pkg::S_DK:   cmd_o.div_sel = pomse_pkg::DV_DK;
      pomse_pkg::S_D2B:  cmd_o.div_sel = pomse_pkg::DV_D2B;
      pomse_pkg::S_D2C:  cmd_o.div_sel = pomse_pkg::DV_D2C;
      pomse_pkg::S_MEAN: cmd_o.div_sel = pomse_pkg::DV_MEAN;
      default:           cmd_o.div_sel = pomse_pkg::DV_DNEW;
    endcase
  end

endmodule

// ----- src/pomse_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pomse_dp
// Sample windows, shared divider, shared multiplier and error accumulator.
// ----------------------------------------------------------------------------
module pomse_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pomse_pkg::in_word_t  in_data_i,
  input  pomse_pkg::cfg_t      cfg_i,
  input  pomse_pkg::dp_cmd_t   cmd_i,
  output pomse_pkg::dp_stat_t  stat_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pomse_pkg::out_word_t out_data_o
);

  pomse_pkg::in_word_t  in_q;
  pomse_pkg::out_word_t out_q;
  pomse_pkg::div_sel_e  dsel_q;
  logic                 out_valid_q;
  logic signed [31:0]   pw_q [3];
  logic signed [31:0]   tw_q [3];
  logic signed [31:0]   fw_q [3];
  logic signed [31:0]   sw_q [3];
  logic [62:0]          es_q, mean_q;
  logic [pomse_pkg::CountW-1:0] cnt_q;
  logic                 flag_q, neg_q, big_q;
  logic signed [31:0]   dnew_q, d2_q, dk_q, v2_q;
  logic [31:0]          mag_q;
  logic signed [51:0]   pred_q;
  logic signed [65:0]   prod_q;

  logic cnt_zero, cnt_one, cnt_two;
  logic signed [31:0] na, nb, da, db;
  logic signed [32:0] numd, dend;
  logic [32:0]        nabs, dabs;
  logic [63:0]        dv_num;
  logic [32:0]        dv_den;
  logic               den_zero, div_start, div_busy, div_done;
  logic [63:0]        quo;
  logic signed [31:0] qsat;

  logic signed [31:0] ax, adx, af;
  logic signed [32:0] ma, mb;
  logic signed [65:0] fl;
  logic signed [51:0] flt, diffv, d2x;
  logic [51:0]        magv;
  logic [62:0]        sq;
  logic [63:0]        sum;
  logic               ge1, ge2;

  assign cnt_zero = (cnt_q == '0);
  assign cnt_one  = (cnt_q == 17'd1);
  assign cnt_two  = (cnt_q == 17'd2);

  assign stat_o.cnt_zero = cnt_zero;
  assign stat_o.cnt_one  = cnt_one;
  assign stat_o.last     = in_q.last_sample;
  assign stat_o.div_busy = div_busy;
  assign stat_o.out_busy = out_valid_q;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

  always_comb begin
    na = '0;
    nb = '0;
    da = '0;
    db = '0;
    unique case (cmd_i.div_sel)
      pomse_pkg::DV_DNEW: begin
        na = in_q.position;
        nb = cnt_one ? pw_q[0] : pw_q[1];
        da = in_q.sample_time;
        db = cnt_one ? tw_q[0] : tw_q[1];
      end
      pomse_pkg::DV_D2A, pomse_pkg::DV_D2B: begin
        na = (cmd_i.div_sel == pomse_pkg::DV_D2A) ? dnew_q : dk_q;
        nb = cnt_two ? sw_q[0] : sw_q[1];
        da = tw_q[0];
        db = cnt_two ? tw_q[1] : tw_q[2];
      end
      pomse_pkg::DV_DK: begin
        na = pw_q[0];
        nb = pw_q[1];
        da = tw_q[0];
        db = tw_q[1];
      end
      pomse_pkg::DV_D2C: begin
        na = dk_q;
        nb = sw_q[0];
        da = tw_q[0];
        db = tw_q[1];
      end
      default: begin
        na = '0;
      end
    endcase
    numd = {na[31], na} - {nb[31], nb};
    dend = {da[31], da} - {db[31], db};
    nabs = numd[32] ? 33'(~numd + 33'sd1) : numd;
    dabs = dend[32] ? 33'(~dend + 33'sd1) : dend;
    if (cmd_i.div_sel == pomse_pkg::DV_MEAN) begin
      dv_num   = {1'b0, es_q};
      dv_den   = {16'd0, cnt_q};
      den_zero = 1'b0;
    end else begin
      dv_num   = {15'd0, nabs, 16'd0};
      dv_den   = dabs;
      den_zero = (dend == '0);
    end
    div_start = cmd_i.div_go && !den_zero;
  end

  pomse_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (dv_num),
    .den_i   (dv_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_comb begin
    if (neg_q) begin
      qsat = (quo > 64'h8000_0000) ? 32'sh8000_0000 : 32'(~quo[31:0] + 32'd1);
    end else begin
      qsat = (quo > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : quo[31:0];
    end
  end

  always_comb begin
    ax  = cmd_i.acc_end ? pw_q[0] : pw_q[1];
    adx = cmd_i.acc_end ? dk_q : sw_q[0];
    af  = cmd_i.acc_end ? fw_q[0] : fw_q[1];
    ge1 = (cfg_i.degree != 2'd0);
    ge2 = cfg_i.degree[1];
    ma  = '0;
    mb  = '0;
    unique case (cmd_i.acc_step)
      pomse_pkg::ST_POS_LIN:  begin ma = {cfg_i.pos_coef1[31], cfg_i.pos_coef1}; mb = {ax[31], ax}; end
      pomse_pkg::ST_POS_SQ:   begin ma = {ax[31], ax}; mb = {ax[31], ax}; end
      pomse_pkg::ST_POS_QUAD: begin ma = {cfg_i.pos_coef2[31], cfg_i.pos_coef2}; mb = {v2_q[31], v2_q}; end
      pomse_pkg::ST_VEL_LIN:  begin ma = {cfg_i.vel_coef1[31], cfg_i.vel_coef1}; mb = {adx[31], adx}; end
      pomse_pkg::ST_VEL_SQ:   begin ma = {adx[31], adx}; mb = {adx[31], adx}; end
      pomse_pkg::ST_VEL_QUAD: begin ma = {cfg_i.vel_coef2[31], cfg_i.vel_coef2}; mb = {v2_q[31], v2_q}; end
      pomse_pkg::ST_FORCE:    begin ma = {cfg_i.force_gain[31], cfg_i.force_gain}; mb = {af[31], af}; end
      pomse_pkg::ST_SQUARE:   begin ma = {1'b0, mag_q}; mb = {1'b0, mag_q}; end
      default:                begin ma = '0; mb = '0; end
    endcase
    fl    = prod_q >>> 16;
    flt   = fl[51:0];
    d2x   = {{20{d2_q[31]}}, d2_q};
    diffv = pred_q - d2x;
    magv  = diffv[51] ? 52'(-diffv) : diffv;
    sq    = big_q ? pomse_pkg::SQ_SAT : prod_q[62:0];
    sum   = {1'b0, es_q} + {1'b0, sq};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_data_i;
    end
    if (cmd_i.div_go) begin
      dsel_q <= cmd_i.div_sel;
      neg_q  <= numd[32] ^ dend[32];
    end
    if (cmd_i.div_go && den_zero) begin
      unique case (cmd_i.div_sel)
        pomse_pkg::DV_DNEW: dnew_q <= '0;
        pomse_pkg::DV_DK:   dk_q   <= '0;
        default:            d2_q   <= '0;
      endcase
    end else if (div_done) begin
      unique case (dsel_q)
        pomse_pkg::DV_DNEW: dnew_q <= qsat;
        pomse_pkg::DV_DK:   dk_q   <= qsat;
        pomse_pkg::DV_MEAN: mean_q <= quo[62:0];
        default:            d2_q   <= qsat;
      endcase
    end
    if (cmd_i.acc_mul) begin
      prod_q <= ma * mb;
    end
    if (cmd_i.acc_post) begin
      unique case (cmd_i.acc_step)
        pomse_pkg::ST_POS_LIN: begin
          pred_q <= {{20{cfg_i.pos_coef0[31]}}, cfg_i.pos_coef0}
                  + {{20{cfg_i.vel_coef0[31]}}, cfg_i.vel_coef0} + (ge1 ? flt : 52'sd0);
        end
        pomse_pkg::ST_POS_SQ, pomse_pkg::ST_VEL_SQ: begin
          v2_q <= (flt[51:31] != '0) ? 32'sh7FFF_FFFF : flt[31:0];
        end
        pomse_pkg::ST_POS_QUAD, pomse_pkg::ST_VEL_QUAD: begin
          if (ge2) pred_q <= pred_q + flt;
        end
        pomse_pkg::ST_VEL_LIN: begin
          if (ge1) pred_q <= pred_q + flt;
        end
        pomse_pkg::ST_FORCE: begin
          pred_q <= pred_q + flt;
        end
        pomse_pkg::ST_RESID: begin
          mag_q <= magv[31:0];
          big_q <= (magv > pomse_pkg::ROOT_MAX);
        end
        default: begin
          big_q <= big_q;
        end
      endcase
    end
    if (cmd_i.emit) begin
      if (cnt_one) begin
        out_q.status        <= pomse_pkg::STATUS_SHORT;
        out_q.mean_sq_error <= '0;
      end else if (flag_q) begin
        out_q.status        <= pomse_pkg::STATUS_ZERO_STEP;
        out_q.mean_sq_error <= '0;
      end else begin
        out_q.status        <= pomse_pkg::STATUS_OK;
        out_q.mean_sq_error <= mean_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      es_q        <= '0;
      cnt_q       <= '0;
      flag_q      <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pw_q[i] <= '0;
        tw_q[i] <= '0;
        fw_q[i] <= '0;
        sw_q[i] <= '0;
      end
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.div_go && den_zero) begin
        flag_q <= 1'b1;
      end
      if (cmd_i.acc_post && (cmd_i.acc_step == pomse_pkg::ST_SQUARE)) begin
        es_q <= (sum > {1'b0, pomse_pkg::SQ_SAT}) ? pomse_pkg::SQ_SAT : sum[62:0];
      end
      if (cmd_i.shift) begin
        pw_q[2] <= pw_q[1];
        pw_q[1] <= pw_q[0];
        pw_q[0] <= in_q.position;
        tw_q[2] <= tw_q[1];
        tw_q[1] <= tw_q[0];
        tw_q[0] <= in_q.sample_time;
        fw_q[2] <= fw_q[1];
        fw_q[1] <= fw_q[0];
        fw_q[0] <= in_q.force_req;
        if (!cnt_zero) begin
          sw_q[2] <= sw_q[1];
          sw_q[1] <= sw_q[0];
          sw_q[0] <= dnew_q;
        end
        cnt_q <= (cnt_q == pomse_pkg::COUNT_CAP) ? pomse_pkg::COUNT_CAP : cnt_q + 17'd1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        es_q        <= '0;
        cnt_q       <= '0;
        flag_q      <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          pw_q[i] <= '0;
          tw_q[i] <= '0;
          fw_q[i] <= '0;
          sw_q[i] <= '0;
        end
      end
    end
  end

endmodule

// ----- src/polynomial_ode_residual_mse.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_ode_residual_mse
// Mean squared residual of a polynomial second-order model over a series.
// ----------------------------------------------------------------------------
// An ordinary word takes two quotients on the shared divider and a multiply
// pass; the first word of a series takes none, the second one quotient. A
// last word adds three more quotients, two multiply passes and the mean
// division; its result leaves through an output register. One word is
// processed at a time. Reset clears the series state and returns the reset
// registers to their reset values at once; there is no clearing pass.
module polynomial_ode_residual_mse (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pomse_pkg::in_word_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pomse_pkg::out_word_t out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  pomse_pkg::cfg_t     cfg;
  pomse_pkg::dp_cmd_t  cmd;
  pomse_pkg::dp_stat_t stat;

  pomse_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pomse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pomse_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_go |-> !stat.div_busy)
    else $error("Divider started while busy.");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !stat.out_busy)
    else $error("Result written over a pending word.");

  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("Second word accepted while one is in work.");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status != pomse_pkg::STATUS_RSVD))
    else $error("Reserved status code on output.");

endmodule

// ----- sim/tb_polynomial_ode_residual_mse.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polynomial_ode_residual_mse
// Self-checking bench for the polynomial ODE residual block. Series of samples
// go in through a queue-fed driver. Each accepted word updates a model of the
// window and error sum. The mean squared error and status that each last
// sample yields are checked against the block's output words. Both sides
// idle at random. The coefficients are rewritten between groups of series.
// ----------------------------------------------------------------------------
module tb_polynomial_ode_residual_mse;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned DrainWait  = 500;
  localparam longint unsigned ErrSat = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint unsigned RootMax = 64'd3037000499;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  pomse_pkg::in_word_t  in_data;
  logic                 out_valid;
  logic                 out_ready;
  pomse_pkg::out_word_t out_data;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [4:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  polynomial_ode_residual_mse uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  pomse_pkg::in_word_t  sample_fifo[$];
  pomse_pkg::out_word_t mse_expect[$];
  int unsigned cycles;
  int unsigned mismatches;
  int unsigned rx_hold;
  bit          calm;
  bit          word_taken;

  // Model of the configuration and the series state.
  int          m_degree;
  int          m_pos[3];
  int          m_vel[3];
  int          m_gain;
  int          pw[3];
  int          tw[3];
  int          fw[3];
  int          sw[3];
  longint unsigned err_sum;
  int          n_seen;
  bit          zero_step;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return int'(v);
  endfunction

  function automatic longint fl16(longint v);
    return v >>> 16;
  endfunction

  function automatic int quotient(longint num, longint den);
    if (den == 0) begin
      zero_step = 1'b1;
      return 0;
    end
    return sat32((num * 65536) / den);
  endfunction

  function automatic longint poly_eval(int c0, int c1, int c2, int deg, int v);
    longint s;
    int v2;
    s = c0;
    if (deg >= 1) s += fl16(longint'(c1) * v);
    if (deg >= 2) begin
      v2 = sat32(fl16(longint'(v) * v));
      s += fl16(longint'(c2) * v2);
    end
    return s;
  endfunction

  function automatic void add_residual(int x, int dx, int f, int d2);
    int deg;
    longint pred;
    longint diff;
    longint unsigned mag;
    longint unsigned sq;
    deg  = (m_degree > 2) ? 2 : m_degree;
    pred = poly_eval(m_pos[0], m_pos[1], m_pos[2], deg, x)
         + poly_eval(m_vel[0], m_vel[1], m_vel[2], deg, dx)
         + fl16(longint'(m_gain) * f);
    diff = pred - d2;
    mag  = (diff < 0) ? longint'(-diff) : diff;
    sq   = (mag > RootMax) ? ErrSat : mag * mag;
    if (sq > ErrSat - err_sum) err_sum = ErrSat;
    else err_sum += sq;
  endfunction

  function automatic void clear_series();
    for (int i = 0; i < 3; i++) begin
      pw[i] = 0;
      tw[i] = 0;
      fw[i] = 0;
      sw[i] = 0;
    end
    err_sum   = 0;
    n_seen    = 0;
    zero_step = 1'b0;
  endfunction

  function automatic bit residual_step(pomse_pkg::in_word_t w,
                                       output pomse_pkg::out_word_t r);
    int t;
    int x;
    int f;
    int k;
    int dnew;
    int d2;
    int dk;
    longint unsigned mean;
    t = w.sample_time;
    x = w.position;
    f = w.force_req;
    k = n_seen;
    r = '0;
    if (k >= 1) begin
      if (k == 1) dnew = quotient(longint'(x) - pw[0], longint'(t) - tw[0]);
      else dnew = quotient(longint'(x) - pw[1], longint'(t) - tw[1]);
      if (k >= 2) begin
        if (k == 2) d2 = quotient(longint'(dnew) - sw[0], longint'(tw[0]) - tw[1]);
        else d2 = quotient(longint'(dnew) - sw[1], longint'(tw[0]) - tw[2]);
        add_residual(pw[1], sw[0], fw[1], d2);
      end
      sw[2] = sw[1];
      sw[1] = sw[0];
      sw[0] = dnew;
    end
    pw[2] = pw[1]; pw[1] = pw[0]; pw[0] = x;
    tw[2] = tw[1]; tw[1] = tw[0]; tw[0] = t;
    fw[2] = fw[1]; fw[1] = fw[0]; fw[0] = f;
    n_seen = (k + 1 > 65536) ? 65536 : k + 1;
    if (!w.last_sample) return 1'b0;
    if (k == 0) begin
      r.status = pomse_pkg::STATUS_SHORT;
    end else begin
      dk = quotient(longint'(pw[0]) - pw[1], longint'(tw[0]) - tw[1]);
      if (k == 1) d2 = quotient(longint'(dk) - sw[0], longint'(tw[0]) - tw[1]);
      else d2 = quotient(longint'(dk) - sw[1], longint'(tw[0]) - tw[2]);
      add_residual(pw[1], sw[0], fw[1], d2);
      d2 = quotient(longint'(dk) - sw[0], longint'(tw[0]) - tw[1]);
      add_residual(pw[0], dk, fw[0], d2);
      if (zero_step) begin
        r.status = pomse_pkg::STATUS_ZERO_STEP;
      end else begin
        mean = err_sum / longint'(n_seen);
        r.mean_sq_error = mean[62:0];
        r.status = pomse_pkg::STATUS_OK;
      end
    end
    clear_series();
    return 1'b1;
  endfunction

  // Checks leaving words, then predicts from the word taken at this edge.
  always @(posedge clk) begin
    pomse_pkg::out_word_t want;
    pomse_pkg::out_word_t got;
    if (rst_n && out_valid && out_ready) begin
      if (mse_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_data);
      end else begin
        want = mse_expect.pop_front();
        if (out_data.mean_sq_error !== want.mean_sq_error
            || out_data.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected mse %h status %0d, got mse %h status %0d",
                     want.mean_sq_error, want.status, out_data.mean_sq_error,
                     out_data.status);
        end
      end
    end
    word_taken = rst_n && in_valid && in_ready;
    if (word_taken && residual_step(in_data, got)) mse_expect.push_back(got);
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || word_taken)) begin
      if (sample_fifo.size() != 0 && (calm || $urandom_range(99) >= 34)) begin
        in_data  <= sample_fifo.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rx_hold != 0) begin
      rx_hold   <= rx_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || $urandom_range(99) >= 34;
    end
  end

  task automatic write_reg(pomse_pkg::reg_idx_e idx, int value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      pomse_pkg::REG_DEGREE:     m_degree = value & 3;
      pomse_pkg::REG_POS_COEF0:  m_pos[0] = value;
      pomse_pkg::REG_POS_COEF1:  m_pos[1] = value;
      pomse_pkg::REG_POS_COEF2:  m_pos[2] = value;
      pomse_pkg::REG_VEL_COEF0:  m_vel[0] = value;
      pomse_pkg::REG_VEL_COEF1:  m_vel[1] = value;
      pomse_pkg::REG_VEL_COEF2:  m_vel[2] = value;
      pomse_pkg::REG_FORCE_GAIN: m_gain = value;
      default: ;
    endcase
  endtask

  task automatic set_coefs(int deg, int c0, int c1, int c2, int v0, int v1, int v2, int g);
    write_reg(pomse_pkg::REG_DEGREE, deg);
    write_reg(pomse_pkg::REG_POS_COEF0, c0);
    write_reg(pomse_pkg::REG_POS_COEF1, c1);
    write_reg(pomse_pkg::REG_POS_COEF2, c2);
    write_reg(pomse_pkg::REG_VEL_COEF0, v0);
    write_reg(pomse_pkg::REG_VEL_COEF1, v1);
    write_reg(pomse_pkg::REG_VEL_COEF2, v2);
    write_reg(pomse_pkg::REG_FORCE_GAIN, g);
  endtask

  task automatic wait_drained();
    wait (sample_fifo.size() == 0 && !in_valid && mse_expect.size() == 0);
    repeat (DrainWait) @(posedge clk);
  endtask

  function automatic int rand_q();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return int'($urandom_range(32'h40000)) - 32'h20000;
      6, 7:             return int'($urandom);
      8:                return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default:          return 0;
    endcase
  endfunction

  function automatic void push_sample(int t, int x, int f, bit last);
    pomse_pkg::in_word_t w;
    w.sample_time = t;
    w.position    = x;
    w.force_req   = f;
    w.last_sample = last;
    sample_fifo.push_back(w);
  endfunction

  // Returns the number of samples queued.
  function automatic int queue_series(int n);
    int t;
    int dt;
    t = int'($urandom_range(32'h20000)) - 32'h10000;
    for (int i = 0; i < n; i++) begin
      push_sample(t, rand_q(), rand_q(), i == n - 1);
      case ($urandom_range(19))
        0:       dt = 0;
        1:       dt = int'($urandom);
        2:       dt = 1;
        default: dt = $urandom_range(32'h30000, 1);
      endcase
      t = (dt == int'($urandom) && dt[0]) ? int'($urandom) : t + dt;
    end
    return n;
  endfunction

  initial begin
    int sent;
    int n;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    cycles    = 0;
    mismatches = 0;
    rx_hold   = 0;
    calm      = 1'b0;
    word_taken = 1'b0;
    m_degree  = 1;
    m_pos     = '{0, 0, 0};
    m_vel     = '{0, 0, 0};
    m_gain    = 0;
    clear_series();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed series under the reset settings, then with set coefficients.
    push_sample(32'h10000, 32'h5000, 32'h100, 1'b1);
    push_sample(0, 32'h10000, 0, 1'b0);
    push_sample(32'h8000, 32'h30000, 32'h2000, 1'b1);
    push_sample(32'h10000, 1, 2, 1'b0);
    push_sample(32'h10000, 3, 4, 1'b0);
    push_sample(32'h20000, 5, 6, 1'b1);
    push_sample(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
    push_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
    push_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
    push_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    push_sample(32'sh8000_0001, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    push_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
    wait_drained();
    set_coefs(2, 32'h10000, -32'sh8000, 32'h4000, 32'h2000, 32'h18000, -32'sh3000, 32'h10000);
    void'(queue_series(4));
    push_sample(0, 32'h10000, 32'h100, 1'b0);
    push_sample(32'h10000, 32'h20000, 32'h200, 1'b0);
    push_sample(32'h20000, 32'h50000, 32'h300, 1'b0);
    push_sample(32'h28000, 32'h48000, 32'h400, 1'b1);
    wait_drained();
    set_coefs(3, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    void'(queue_series(3));
    wait_drained();
    set_coefs(0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    void'(queue_series(3));
    wait_drained();

    // Random phases: well-formed series of random length and content.
    sent = 25;
    for (int ph = 0; sent < 1350; ph++) begin
      if ($urandom_range(3) == 0)
        set_coefs($urandom_range(3), rand_q(), rand_q(), rand_q(), rand_q(),
                  rand_q(), rand_q(), rand_q());
      else
        set_coefs($urandom_range(3), int'($urandom_range(32'h40000)) - 32'h20000,
                  int'($urandom_range(32'h40000)) - 32'h20000,
                  int'($urandom_range(32'h8000)) - 32'h4000,
                  int'($urandom_range(32'h40000)) - 32'h20000,
                  int'($urandom_range(32'h40000)) - 32'h20000,
                  int'($urandom_range(32'h8000)) - 32'h4000,
                  int'($urandom_range(32'h40000)) - 32'h20000);
      calm = (ph == 3);
      if (ph == 1) rx_hold = 3000;
      for (int s = 0; s < 12; s++) begin
        case ($urandom_range(9))
          0:       n = 1;
          1:       n = 2;
          2:       n = $urandom_range(40, 13);
          default: n = $urandom_range(12, 3);
        endcase
        sent += queue_series(n);
      end
      wait_drained();
    end
    calm = 1'b0;
    wait_drained();
    if (mismatches == 0 && mse_expect.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- polynomial_ode_residual_mse.f -----
src/pomse_pkg.sv
src/pomse_regs.sv
src/pomse_div.sv
src/pomse_ctrl.sv
src/pomse_dp.sv
src/polynomial_ode_residual_mse.sv
sim/tb_polynomial_ode_residual_mse.sv
